[rtl/npp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npp_pkg
// Shared types, widths and helpers for the nearest-point-on-polylines block.
// ----------------------------------------------------------------------------
package npp_pkg;

  localparam int COORD_W  = 32;
  localparam int ROAD_W   = 16;
  localparam int SQ_W     = 64;
  localparam int PROD_W   = 64;
  localparam int LEN2_W   = 65;  // |dx|^2 + |dy|^2
  localparam int DOT_W    = 66;  // signed dot product

  localparam int RATIO_FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] seg_start_x;
    logic signed [COORD_W-1:0] seg_start_y;
    logic signed [COORD_W-1:0] seg_end_x;
    logic signed [COORD_W-1:0] seg_end_y;
    logic        [ROAD_W-1:0]  road_index;
    logic                      last_segment;
  } npp_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic        [ROAD_W-1:0]  nearest_road;
    logic        [SQ_W-1:0]    sq_distance;
    logic                      found;
  } npp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_A,
    ST_LEN_B,
    ST_DOT_A,
    ST_DOT_B,
    ST_DOT_C,
    ST_DECIDE,
    ST_DIV,
    ST_PROJ_X,
    ST_PROJ_Y,
    ST_ERR_X,
    ST_ERR_Y,
    ST_SQ_A,
    ST_UPDATE,
    ST_EMIT
  } npp_state_t;

  typedef struct packed {
    npp_state_t state;
    logic       div_start;
    logic       emit;
  } npp_ctl_t;

  typedef struct packed {
    logic in_xfer;
    logic in_degen;
    logic in_last;
    logic last;
    logic trivial;
    logic div_done;
    logic out_free;
  } npp_sts_t;

  // |a - b| for two signed coordinates; always fits in 32 unsigned bits
  function automatic logic [COORD_W-1:0] absdiff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic [COORD_W:0] d_ab;
    logic [COORD_W:0] d_ba;
    d_ab = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    d_ba = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    return (a < b) ? d_ba[COORD_W-1:0] : d_ab[COORD_W-1:0];
  endfunction

endpackage : npp_pkg
`default_nettype wire

[rtl/npp_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npp_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module npp_mul
  import npp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [COORD_W-1:0]  a,
  input  wire logic [COORD_W-1:0]  b,
  output logic      [PROD_W-1:0]   p_r
);

  logic [PROD_W-1:0] p_nxt;

  assign p_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule : npp_mul
`default_nettype wire

[rtl/npp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npp_div
// Restoring divider for the projection ratio: floor(num * 2^R / den), num < den.
// One quotient bit per cycle; done pulses the cycle after the last bit.
// ----------------------------------------------------------------------------
module npp_div
  import npp_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [LEN2_W-1:0]           num,
  input  wire logic [LEN2_W-1:0]           den,
  output logic      [RATIO_FRAC_BITS-1:0]  q_r,
  output logic                             done_r
);

  localparam int CNT_W = $clog2(RATIO_FRAC_BITS);

  logic [LEN2_W-1:0] rem_r;
  logic [LEN2_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              last_step;
  logic [LEN2_W:0]   shifted;
  logic [LEN2_W+1:0] diff;
  logic              ge;

  assign shifted   = {rem_r, 1'b0};
  assign diff      = {1'b0, shifted} - {2'b00, den_r};
  assign ge        = ~diff[LEN2_W+1];
  assign last_step = busy_r && (cnt_r == CNT_W'(RATIO_FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last_step) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[LEN2_W-1:0] : shifted[LEN2_W-1:0];
      q_r   <= {q_r[RATIO_FRAC_BITS-2:0], ge};
    end
  end

endmodule : npp_div
`default_nettype wire

[rtl/npp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npp_ctrl
// Sequencer: steps one segment through the shared multiplier and divider.
// ----------------------------------------------------------------------------
module npp_ctrl
  import npp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire npp_sts_t sts,
  output npp_ctl_t      ctl
);

  npp_state_t state_r;
  npp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.in_xfer) begin
          if (sts.in_degen) begin
            state_nxt = sts.in_last ? ST_EMIT : ST_IDLE;
          end else begin
            state_nxt = ST_LEN_A;
          end
        end
      end
      ST_LEN_A:  state_nxt = ST_LEN_B;
      ST_LEN_B:  state_nxt = ST_DOT_A;
      ST_DOT_A:  state_nxt = ST_DOT_B;
      ST_DOT_B:  state_nxt = ST_DOT_C;
      ST_DOT_C:  state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = sts.trivial ? ST_PROJ_X : ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_PROJ_X;
        end
      end
      ST_PROJ_X: state_nxt = ST_PROJ_Y;
      ST_PROJ_Y: state_nxt = ST_ERR_X;
      ST_ERR_X:  state_nxt = ST_ERR_Y;
      ST_ERR_Y:  state_nxt = ST_SQ_A;
      ST_SQ_A:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = sts.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.state     = state_r;
    ctl.div_start = (state_r == ST_DECIDE) && !sts.trivial;
    ctl.emit      = (state_r == ST_EMIT) && sts.out_free;
  end

endmodule : npp_ctrl
`default_nettype wire

[rtl/nearest_point_on_polylines_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// A segment of nonzero length steps through the length, dot product, decide, projection,
//   error, square and update states, plus the divide state when the ratio needs the divider.
// A zero-length segment is skipped from the idle state. A last segment passes through the
//   emit state to load the result, and waits there while an earlier result still waits in the output register.
// The input stays stalled until the current segment is through, since the multiplier is shared
//   and the divider is bit-serial. Synchronous active-low reset clears the running best.
// ----------------------------------------------------------------------------
// nearest_point_on_polylines_top
// Projects a query point onto each nonzero-length segment, keeps the nearest projection.
// ----------------------------------------------------------------------------
module nearest_point_on_polylines_top
  import npp_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire npp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output npp_out_t      out_data
);

  localparam int RW = RATIO_FRAC_BITS + 1;
  localparam logic [RW-1:0]     RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] RND_HALF  = PROD_W'(1) << (RATIO_FRAC_BITS - 1);

  npp_ctl_t ctl;
  npp_sts_t sts;

  // item registers
  logic signed [COORD_W-1:0] qx_r, qy_r, x1_r, y1_r;
  logic [COORD_W-1:0]        mdx_r, mdy_r, max_r, may_r;
  logic                      sdx_r, sdy_r, sax_r, say_r;
  logic [ROAD_W-1:0]         road_r;
  logic                      last_r;

  // working registers
  logic [LEN2_W-1:0]         len2_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic [RW-1:0]             ratio_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [COORD_W-1:0]        ex_r, ey_r;
  logic [PROD_W-1:0]         sx_r;

  // running best
  logic [SQ_W-1:0]           best_sq_r;
  logic signed [COORD_W-1:0] best_x_r, best_y_r;
  logic [ROAD_W-1:0]         best_road_r;
  logic                      seen_r;

  npp_out_t                  out_data_r;
  logic                      out_valid_r;

  logic                      in_xfer;
  logic [COORD_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]         prod_r;
  logic [RATIO_FRAC_BITS-1:0] div_q;
  logic                      div_done;
  logic [DOT_W-1:0]          dprod;
  logic                      dot_neg, dot_zero, dot_ge;
  logic [PROD_W-1:0]         rnd_sum;
  logic [COORD_W:0]          off;
  logic [COORD_W+1:0]        base_ext, proj_full;
  logic                      proj_neg;
  logic signed [COORD_W-1:0] proj_base;
  logic [SQ_W:0]             sq_sum;
  logic [SQ_W-1:0]           sq;

  assign in_stall = (ctl.state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  npp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  npp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  npp_div #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.div_start),
    .num    (dot_r[LEN2_W-1:0]),
    .den    (len2_r),
    .q_r    (div_q),
    .done_r (div_done)
  );

  // ratio decision on the finished dot product
  assign dot_neg  = dot_r[DOT_W-1];
  assign dot_zero = (dot_r == '0);
  assign dot_ge   = (dot_r[LEN2_W-1:0] >= len2_r);

  always_comb begin
    sts.in_xfer  = in_xfer;
    sts.in_degen = (in_data.seg_start_x == in_data.seg_end_x) &&
                   (in_data.seg_start_y == in_data.seg_end_y);
    sts.in_last  = in_data.last_segment;
    sts.last     = last_r;
    sts.trivial  = dot_neg || dot_zero || dot_ge;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // operand select for the shared multiplier
  always_comb begin
    case (ctl.state)
      ST_LEN_A:  begin mul_a = mdx_r; mul_b = mdx_r;            end
      ST_LEN_B:  begin mul_a = mdy_r; mul_b = mdy_r;            end
      ST_DOT_A:  begin mul_a = max_r; mul_b = mdx_r;            end
      ST_DOT_B:  begin mul_a = may_r; mul_b = mdy_r;            end
      ST_PROJ_X: begin mul_a = mdx_r; mul_b = COORD_W'(ratio_r); end
      ST_PROJ_Y: begin mul_a = mdy_r; mul_b = COORD_W'(ratio_r); end
      ST_ERR_Y:  begin mul_a = ex_r;  mul_b = ex_r;             end
      ST_SQ_A:   begin mul_a = ey_r;  mul_b = ey_r;             end
      default:   begin mul_a = '0;    mul_b = '0;               end
    endcase
  end

  assign dprod = {2'b00, prod_r};

  // base +/- round(|d| * ratio / 2^R); stays between the vertices
  assign proj_neg  = (ctl.state == ST_PROJ_Y) ? sdx_r : sdy_r;
  assign proj_base = (ctl.state == ST_PROJ_Y) ? x1_r : y1_r;
  assign rnd_sum   = prod_r + RND_HALF;
  assign off       = rnd_sum[RATIO_FRAC_BITS +: (COORD_W + 1)];
  assign base_ext  = {{2{proj_base[COORD_W-1]}}, proj_base};
  assign proj_full = proj_neg ? (base_ext - {1'b0, off}) : (base_ext + {1'b0, off});

  assign sq_sum = {1'b0, sx_r} + {1'b0, prod_r};
  assign sq     = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      qx_r   <= in_data.query_x;
      qy_r   <= in_data.query_y;
      x1_r   <= in_data.seg_start_x;
      y1_r   <= in_data.seg_start_y;
      mdx_r  <= absdiff(in_data.seg_end_x, in_data.seg_start_x);
      mdy_r  <= absdiff(in_data.seg_end_y, in_data.seg_start_y);
      max_r  <= absdiff(in_data.query_x, in_data.seg_start_x);
      may_r  <= absdiff(in_data.query_y, in_data.seg_start_y);
      sdx_r  <= (in_data.seg_end_x < in_data.seg_start_x);
      sdy_r  <= (in_data.seg_end_y < in_data.seg_start_y);
      sax_r  <= (in_data.query_x < in_data.seg_start_x);
      say_r  <= (in_data.query_y < in_data.seg_start_y);
      road_r <= in_data.road_index;
      last_r <= in_data.last_segment;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.state)
      ST_LEN_B:  len2_r <= {1'b0, prod_r};
      ST_DOT_A:  len2_r <= len2_r + {1'b0, prod_r};
      ST_DOT_B:  dot_r  <= (sax_r ^ sdx_r) ? -$signed(dprod) : $signed(dprod);
      ST_DOT_C:  dot_r  <= (say_r ^ sdy_r) ? (dot_r - $signed(dprod))
                                           : (dot_r + $signed(dprod));
      ST_DECIDE: begin
        if (dot_neg || dot_zero) begin
          ratio_r <= '0;
        end else if (dot_ge) begin
          ratio_r <= RATIO_ONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ratio_r <= {1'b0, div_q};
        end
      end
      ST_PROJ_Y: px_r <= proj_full[COORD_W-1:0];
      ST_ERR_X: begin
        py_r <= proj_full[COORD_W-1:0];
        ex_r <= absdiff(qx_r, px_r);
      end
      ST_ERR_Y:  ey_r <= absdiff(qy_r, py_r);
      ST_SQ_A:   sx_r <= prod_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sq_r   <= '1;
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_road_r <= '0;
      seen_r      <= 1'b0;
    end else if (ctl.emit) begin
      best_sq_r   <= '1;
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_road_r <= '0;
      seen_r      <= 1'b0;
    end else if (ctl.state == ST_UPDATE) begin
      seen_r <= 1'b1;
      // ties go to the later segment
      if (sq <= best_sq_r) begin
        best_sq_r   <= sq;
        best_x_r    <= px_r;
        best_y_r    <= py_r;
        best_road_r <= road_r;
      end
    end
  end

  // output register: the input side stays open while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data_r.near_x       <= best_x_r;
      out_data_r.near_y       <= best_y_r;
      out_data_r.nearest_road <= best_road_r;
      out_data_r.sq_distance  <= best_sq_r;
      out_data_r.found        <= seen_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.state == ST_EMIT))
    else $error("result loaded outside the emit state");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.state == ST_PROJ_X) |-> (ratio_r <= RATIO_ONE))
    else $error("projection ratio above one");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> (best_sq_r == '1) && !seen_r)
    else $error("running best not cleared after a result");
`endif

endmodule : nearest_point_on_polylines_top
`default_nettype wire

[tb/nearest_point_on_polylines_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_on_polylines_top_tb
// Sends query/segment transfers through the nearest-point search and checks
// every emitted result against a behavioral predictor that tracks the running
// nearest projection. It covers directed corner cases first, then random
// queries under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module nearest_point_on_polylines_top_tb;
  import npp_pkg::*;

  localparam int RATIO_BITS = RATIO_FRAC_BITS_DEF;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE = 32'sd4194304;  // 1.0 with 22 fraction bits
  localparam logic signed [127:0] SQ_SAT = {64'd0, {64{1'b1}}};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  npp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  npp_out_t out_data;

  // running nearest projection of the current query
  logic [63:0]        best_dist;
  logic signed [31:0] best_px;
  logic signed [31:0] best_py;
  logic [15:0]        best_rd;
  logic               any_seen;
  npp_out_t           expected_nearest[$];

  int send_idle_pct = 13;
  int recv_stall_pct = 64;
  int errors = 0;
  int items_sent = 0;
  int query_count = 0;
  int found_count = 0;
  int zero_len_count = 0;

  nearest_point_on_polylines_top #(
    .RATIO_FRAC_BITS(RATIO_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  task automatic clear_nearest();
    best_dist = '1;
    best_px = '0;
    best_py = '0;
    best_rd = '0;
    any_seen = 1'b0;
  endtask

  // offset = round(|d| * ratio / 2^R), half away from zero, sign of d applied
  function automatic logic signed [127:0] project_axis(input logic signed [127:0] base,
                                                       input logic signed [127:0] d,
                                                       input logic signed [127:0] frac);
    logic signed [127:0] mag;
    logic signed [127:0] off;
    mag = (d < 0) ? -d : d;
    off = (mag * frac + (128'sd1 <<< (RATIO_BITS - 1))) >>> RATIO_BITS;
    return (d < 0) ? base - off : base + off;
  endfunction

  task automatic track_segment(input npp_in_t it);
    logic signed [127:0] qx, qy, x1, y1, dx, dy;
    logic signed [127:0] len2, dot, ratio, px, py, ex, ey, sq;
    npp_out_t res;
    qx = $signed(it.query_x);
    qy = $signed(it.query_y);
    x1 = $signed(it.seg_start_x);
    y1 = $signed(it.seg_start_y);
    dx = $signed(it.seg_end_x) - x1;
    dy = $signed(it.seg_end_y) - y1;
    if (dx == 0 && dy == 0) begin
      zero_len_count++;
    end else begin
      len2 = dx * dx + dy * dy;
      dot = (qx - x1) * dx + (qy - y1) * dy;
      if (dot <= 0) begin
        ratio = 0;
      end else if (dot >= len2) begin
        ratio = 128'sd1 <<< RATIO_BITS;
      end else begin
        ratio = (dot <<< RATIO_BITS) / len2;
      end
      px = project_axis(x1, dx, ratio);
      py = project_axis(y1, dy, ratio);
      ex = qx - px;
      ey = qy - py;
      sq = ex * ex + ey * ey;
      if (sq > SQ_SAT) sq = SQ_SAT;
      // ties and saturated distances go to the later segment
      if (sq[63:0] <= best_dist) begin
        best_dist = sq[63:0];
        best_px = px[31:0];
        best_py = py[31:0];
        best_rd = it.road_index;
      end
      any_seen = 1'b1;
    end
    if (it.last_segment) begin
      res.near_x = best_px;
      res.near_y = best_py;
      res.nearest_road = best_rd;
      res.sq_distance = best_dist;
      res.found = any_seen;
      expected_nearest.push_back(res);
      query_count++;
      if (any_seen) found_count++;
      clear_nearest();
    end
  endtask

  // ------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    npp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_nearest.size() == 0) begin
        $error("unexpected result transfer: nearest_road %0d", out_data.nearest_road);
        errors++;
      end else begin
        want = expected_nearest.pop_front();
        if (out_data.near_x !== want.near_x) begin
          $error("near_x: expected %0d, got %0d", want.near_x, out_data.near_x);
          errors++;
        end
        if (out_data.near_y !== want.near_y) begin
          $error("near_y: expected %0d, got %0d", want.near_y, out_data.near_y);
          errors++;
        end
        if (out_data.nearest_road !== want.nearest_road) begin
          $error("nearest_road: expected %0d, got %0d", want.nearest_road,
                 out_data.nearest_road);
          errors++;
        end
        if (out_data.sq_distance !== want.sq_distance) begin
          $error("sq_distance: expected %0d, got %0d", want.sq_distance,
                 out_data.sq_distance);
          errors++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic send_item(input npp_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    track_segment(it);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_nearest.size() != 0) @(posedge clk);
  endtask

  function automatic npp_in_t build_item(input logic signed [31:0] qx, qy,
                                         input logic signed [31:0] sx, sy, ex, ey,
                                         input logic [15:0] road, input logic last);
    npp_in_t it;
    it.query_x = qx;
    it.query_y = qy;
    it.seg_start_x = sx;
    it.seg_start_y = sy;
    it.seg_end_x = ex;
    it.seg_end_y = ey;
    it.road_index = road;
    it.last_segment = last;
    return it;
  endfunction

  function automatic logic signed [31:0] jitter(input logic signed [31:0] base,
                                                input int unsigned span);
    return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_query();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom;
      6, 7, 8: return jitter(32'sd0, 32'd1 << 24);
      default: return pick_extreme();
    endcase
  endfunction

  function automatic npp_in_t make_segment(input logic signed [31:0] qx, qy,
                                           input logic [15:0] road, input logic last);
    int unsigned span;
    logic signed [31:0] sx, sy, ex, ey, vx, vy;
    span = 32'd1 << $urandom_range(2, 22);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        sx = $urandom;
        sy = $urandom;
        ex = $urandom;
        ey = $urandom;
      end
      4, 5, 6: begin  // short segment around the query
        sx = jitter(qx, span);
        sy = jitter(qy, span);
        ex = jitter(qx, span);
        ey = jitter(qy, span);
      end
      7: begin  // zero length
        sx = jitter(qx, span);
        sy = jitter(qy, span);
        ex = sx;
        ey = sy;
      end
      8: begin
        sx = pick_extreme();
        sy = pick_extreme();
        ex = pick_extreme();
        ey = pick_extreme();
      end
      default: begin  // query sits at the segment midpoint
        vx = jitter(32'sd0, span);
        vy = jitter(32'sd0, span);
        sx = qx - vx;
        sy = qy - vy;
        ex = qx + vx;
        ey = qy + vy;
      end
    endcase
    return build_item(qx, qy, sx, sy, ex, ey, road, last);
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  task automatic test_empty_queries();
    send_item(build_item(0, 0, 5, 5, 5, 5, 16'd7, 1'b1));
    send_item(build_item(C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 16'hFFFF, 1'b1));
  endtask

  task automatic test_projection_cases();
    // clamped at the start, clamped at the end, dot of zero, divider, plain
    send_item(build_item(3*ONE, 4*ONE, 5*ONE, 0, 9*ONE, 0, 16'd1, 1'b0));
    send_item(build_item(3*ONE, 4*ONE, -9*ONE, 0, -5*ONE, 0, 16'd2, 1'b0));
    send_item(build_item(3*ONE, 4*ONE, 0, 0, -4*ONE, 3*ONE, 16'd3, 1'b0));
    send_item(build_item(3*ONE, 4*ONE, 0, 0, 7*ONE, 1, 16'hFFFF, 1'b0));
    send_item(build_item(3*ONE, 4*ONE, ONE, 5*ONE, 5*ONE, 3*ONE, 16'd0, 1'b1));
    // full-range segments
    send_item(build_item(0, 0, C_MIN, C_MIN, C_MAX, C_MAX, 16'h8000, 1'b0));
    send_item(build_item(0, 0, C_MAX, C_MIN, C_MIN, C_MAX, 16'h7FFF, 1'b1));
    send_item(build_item(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 16'h5555, 1'b1));
    send_item(build_item(-1, C_MAX, C_MIN, 0, C_MAX, -1, 16'hAAAA, 1'b1));
  endtask

  task automatic test_ties_and_saturation();
    send_item(build_item(ONE, ONE, 0, 0, 2*ONE, 0, 16'd10, 1'b0));
    send_item(build_item(ONE, ONE, 0, 0, 2*ONE, 0, 16'd11, 1'b0));
    // zero length right on the query: must not win
    send_item(build_item(ONE, ONE, ONE, ONE, ONE, ONE, 16'd12, 1'b0));
    send_item(build_item(ONE, ONE, 0, 0, 0, 2*ONE, 16'd13, 1'b1));
    // both distances saturate; the later one still takes over
    send_item(build_item(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX - 1, 16'd20, 1'b0));
    send_item(build_item(C_MIN, C_MIN, C_MAX, C_MAX - 1, C_MAX, C_MAX, 16'd21, 1'b1));
  endtask

  task automatic test_random(input int n_items, input int s_idle, input int r_stall);
    int sent;
    int group_len;
    int k;
    logic paused;
    logic scramble;
    logic signed [31:0] qx, qy;
    logic [15:0] road;
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      group_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      scramble = ($urandom_range(0, 9) == 0);  // query changes inside the group
      qx = pick_query();
      qy = pick_query();
      road = 16'($urandom);
      for (k = 0; k < group_len; k++) begin
        if (scramble) begin
          qx = pick_query();
          qy = pick_query();
        end
        if ($urandom_range(0, 2) == 0) road = 16'($urandom);
        send_item(make_segment(qx, qy, road, k == group_len - 1));
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    clear_nearest();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queries();
    test_projection_cases();
    test_ties_and_saturation();
    test_random(360, 13, 64);
    test_random(360, 64, 13);
    test_random(360, 0, 0);
    drain_results();
    repeat (40) @(posedge clk);
    $display("Ran %0d segment transfers over %0d queries (%0d with a nearest point).",
             items_sent, query_count, found_count);
    $display("Zero-length segments skipped: %0d; idle mixes: 13/64, 64/13, none.",
             zero_len_count);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
